// ===== rtl/uart_idle_timeout_frame_receiver_macros.svh =====
// Assertion macros for the frame receiver.
`ifndef UART_IDLE_TIMEOUT_FRAME_RECEIVER_MACROS_SVH
`define UART_IDLE_TIMEOUT_FRAME_RECEIVER_MACROS_SVH

// Checked on every rising edge of clk, quiet while rst_n is low.
`define UITFR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define UITFR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/uitfr_pkg.sv =====
package uitfr_pkg;

    // Default buffer depth in bytes
    localparam int DEF_BUF_DEPTH = 256;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 8;
    localparam int IDLE_W   = 16;
    localparam int LIMIT_W  = 9;
    localparam int COUNT_W  = 17;
    localparam int LENGTH_W = 9;

    // Stream data widths, padded to whole bytes
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_BYTE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_IDLE_TICKS   = 1'b0;
    localparam logic REG_BUFFER_LIMIT = 1'b1;

    localparam logic [IDLE_W-1:0]  IDLE_TICKS_RST   = 16'd0;
    localparam logic [LIMIT_W-1:0] BUFFER_LIMIT_RST = 9'd256;

    typedef struct packed {
        logic [IDLE_W-1:0]  idle_ticks;
        logic [LIMIT_W-1:0] buffer_limit;
    } cfg_t;

    // Per-item status from the frame control to the result stage
    typedef struct packed {
        logic frame_done;
        logic overflow;
        logic rd_hit;
    } step_stat_t;

endpackage

// ===== rtl/uitfr_regs.sv =====
module uitfr_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [uitfr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [uitfr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [uitfr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready,
    output uitfr_pkg::cfg_t                   cfg
);
    import uitfr_pkg::*;

    logic [IDLE_W-1:0]  idle_ticks_reg;
    logic [LIMIT_W-1:0] buffer_limit_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    // Register writes, one register per word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_ticks_reg   <= IDLE_TICKS_RST;
            buffer_limit_reg <= BUFFER_LIMIT_RST;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_IDLE_TICKS:   idle_ticks_reg   <= pwdata[IDLE_W-1:0];
                REG_BUFFER_LIMIT: buffer_limit_reg <= pwdata[LIMIT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (paddr[2])
            REG_IDLE_TICKS:   prdata = APB_DATA_W'(idle_ticks_reg);
            REG_BUFFER_LIMIT: prdata = APB_DATA_W'(buffer_limit_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.idle_ticks   = idle_ticks_reg;
    assign cfg.buffer_limit = buffer_limit_reg;

endmodule

// ===== rtl/uitfr_buffer.sv =====
module uitfr_buffer #(
    parameter int BUF_DEPTH = uitfr_pkg::DEF_BUF_DEPTH,
    parameter int AW        = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [uitfr_pkg::BYTE_W-1:0]  wr_data,
    input  logic                          rd_en,
    input  logic [AW-1:0]                 rd_addr,
    output logic [uitfr_pkg::BYTE_W-1:0]  rd_data
);
    import uitfr_pkg::*;

    logic [BYTE_W-1:0] mem [BUF_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/uitfr_ctrl.sv =====
module uitfr_ctrl #(
    parameter int BUF_DEPTH = uitfr_pkg::DEF_BUF_DEPTH,
    parameter int AW        = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1,
    parameter int LEN_W     = $clog2(BUF_DEPTH + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            acc,
    input  logic [uitfr_pkg::CMD_W-1:0]     cmd,
    input  logic [uitfr_pkg::BYTE_W-1:0]    rx_byte,
    input  logic [uitfr_pkg::INDEX_W-1:0]   read_index,
    input  uitfr_pkg::cfg_t                 cfg,
    output uitfr_pkg::step_stat_t           stat,
    output logic [uitfr_pkg::LENGTH_W-1:0]  length,
    output logic                            frame_open,
    output logic                            mem_wr_en,
    output logic [AW-1:0]                   mem_wr_addr,
    output logic [uitfr_pkg::BYTE_W-1:0]    mem_wr_data,
    output logic                            mem_rd_en,
    output logic [AW-1:0]                   mem_rd_addr
);
    import uitfr_pkg::*;

    localparam int CMP_W = (LEN_W > LIMIT_W) ? LEN_W : LIMIT_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(BUF_DEPTH);

    logic               frame_open_reg, frame_open_next;
    logic [COUNT_W-1:0] idle_count_reg, idle_count_next;
    logic [LEN_W-1:0]   length_reg, length_next;
    logic               overflow_reg, overflow_next;

    logic [CMP_W-1:0]   limit_ext, eff_limit, base_len, idx_ext;
    logic               base_ovf;

    assign limit_ext = CMP_W'(cfg.buffer_limit);
    assign eff_limit = (limit_ext > DEPTH_C) ? DEPTH_C : limit_ext;
    assign idx_ext   = CMP_W'(read_index);

    // A byte on a closed frame starts a new one
    assign base_len = frame_open_reg ? CMP_W'(length_reg) : '0;
    assign base_ovf = frame_open_reg & overflow_reg;

    // Next state of the frame for this item
    always_comb
    begin
        frame_open_next = frame_open_reg;
        idle_count_next = idle_count_reg;
        length_next     = length_reg;
        overflow_next   = overflow_reg;
        stat            = '0;
        mem_wr_en       = 1'b0;
        mem_rd_en       = 1'b0;
        case (cmd)
            CMD_BYTE:
            begin
                frame_open_next = 1'b1;
                idle_count_next = '0;
                length_next     = base_len[LEN_W-1:0];
                overflow_next   = base_ovf;
                if (base_len >= eff_limit)
                begin
                    overflow_next = 1'b1;
                end
                else if (base_len < DEPTH_C)
                begin
                    mem_wr_en   = acc;
                    length_next = base_len[LEN_W-1:0] + LEN_W'(1);
                end
            end
            CMD_TICK:
            begin
                if (frame_open_reg)
                begin
                    idle_count_next = idle_count_reg + COUNT_W'(1);
                    if (idle_count_reg >= COUNT_W'(cfg.idle_ticks))
                    begin
                        stat.frame_done = 1'b1;
                        idle_count_next = '0;
                        frame_open_next = 1'b0;
                    end
                end
            end
            CMD_READ:
            begin
                if (idx_ext < CMP_W'(length_reg) && idx_ext < DEPTH_C)
                begin
                    stat.rd_hit = 1'b1;
                    mem_rd_en   = acc;
                end
            end
            default: ;
        endcase
        stat.overflow = overflow_next;
    end

    // Frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
            idle_count_reg <= '0;
            length_reg     <= '0;
            overflow_reg   <= 1'b0;
        end
        else if (acc)
        begin
            frame_open_reg <= frame_open_next;
            idle_count_reg <= idle_count_next;
            length_reg     <= length_next;
            overflow_reg   <= overflow_next;
        end
    end

    assign mem_wr_addr = base_len[AW-1:0];
    assign mem_wr_data = rx_byte;
    assign mem_rd_addr = idx_ext[AW-1:0];
    assign length      = LENGTH_W'(CMP_W'(length_next));
    assign frame_open  = frame_open_reg;

endmodule

// ===== rtl/uart_idle_timeout_frame_receiver.sv =====
// Pipeline: an accepted input passes the buffer read stage, then the output register, to the result.
// Throughput: one item per cycle while m_tready does not stall the output; state is updated in the
// accept cycle and the frame buffer has one write and one registered read port.
// Reset: rst_n clears the frame state, the config registers and both pipeline
// stages; the frame buffer is not cleared and needs no clearing pass.
module uart_idle_timeout_frame_receiver #(
    parameter int BUF_DEPTH = uitfr_pkg::DEF_BUF_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // cmd[1:0], rx_byte[9:2], read_index[17:10], zero pad
    input  logic [uitfr_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // frame_length[8:0], overflow[9], read_data[17:10], zero pad
    output logic [uitfr_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                              m_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [uitfr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [uitfr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [uitfr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready
);
    import uitfr_pkg::*;
    `include "uart_idle_timeout_frame_receiver_macros.svh"

    localparam int AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int LEN_W = $clog2(BUF_DEPTH + 1);

    cfg_t               cfg;
    step_stat_t         stat;
    logic [LENGTH_W-1:0] length;
    logic               frame_open;
    logic               mem_wr_en, mem_rd_en;
    logic [AW-1:0]      mem_wr_addr, mem_rd_addr;
    logic [BYTE_W-1:0]  mem_wr_data, mem_rd_data;

    logic               acc, out_free, s1_move;

    logic               s1_valid_reg;
    step_stat_t         s1_stat_reg;
    logic [LENGTH_W-1:0] s1_len_reg;

    logic               m_valid_reg;
    logic               m_last_reg;
    logic [LENGTH_W-1:0] m_len_reg;
    logic               m_ovf_reg;
    logic [BYTE_W-1:0]  m_data_reg;

    // Handshake
    assign out_free = !m_valid_reg || m_tready;
    assign s1_move  = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign acc      = s_tvalid && s_tready;

    uitfr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    uitfr_ctrl #(
        .BUF_DEPTH (BUF_DEPTH),
        .AW        (AW),
        .LEN_W     (LEN_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .acc         (acc),
        .cmd         (s_tdata[1:0]),
        .rx_byte     (s_tdata[9:2]),
        .read_index  (s_tdata[17:10]),
        .cfg         (cfg),
        .stat        (stat),
        .length      (length),
        .frame_open  (frame_open),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr)
    );

    uitfr_buffer #(
        .BUF_DEPTH (BUF_DEPTH),
        .AW        (AW)
    ) u_buffer (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Stage 1: waits for the buffer read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (acc)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_stat_reg <= stat;
            s1_len_reg  <= length;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            m_last_reg <= s1_stat_reg.frame_done;
            m_len_reg  <= s1_len_reg;
            m_ovf_reg  <= s1_stat_reg.overflow;
            m_data_reg <= s1_stat_reg.rd_hit ? mem_rd_data : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {6'd0, m_data_reg, m_ovf_reg, m_len_reg};

    // Checks
    `UITFR_ASSERT(a_done_closes, acc && stat.frame_done |=> !frame_open, "frame stayed open after timeout")
    `UITFR_ASSERT(a_s1_no_overwrite, s1_valid_reg && !out_free |-> !s_tready, "stage 1 overwritten while stalled")
    `UITFR_ASSERT(a_len_in_depth, LEN_W'(length) <= LEN_W'(BUF_DEPTH) || !acc, "frame length beyond buffer depth")
    `UITFR_ASSERT_ALWAYS(a_no_wr_rd_same, mem_wr_en && mem_rd_en |-> 1'b0, "buffer write and read in one item")

endmodule
